// ===== sv/bls_pkg.sv =====
// Shared types and constants of the line stepper.
`timescale 1ns / 1ps

package bls_pkg;

    localparam int COORD_W   = 12;
    localparam int DELTA_W   = 12;
    localparam int ERR_W     = 14;
    localparam int COLOR_W   = 32;
    localparam int LEFT_W    = 9;
    localparam int ADDR_W    = 17;
    localparam int CFG_IDX_W = 2;

    // Item opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DRAW_COLOR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_LEFT = 2'd1;

    localparam logic [COLOR_W-1:0] DRAW_COLOR_RST  = 32'hFFEE_D6DC;
    localparam logic [LEFT_W-1:0]  CANVAS_LEFT_RST = 9'd80;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [DELTA_W-1:0]        delta_t;
    typedef logic signed [ERR_W-1:0]   err_t;

    typedef struct packed {
        coord_t cur_x;
        coord_t cur_y;
        coord_t target_x;
        coord_t target_y;
        delta_t abs_dx;
        delta_t abs_dy;
        logic   dir_x_neg;
        logic   dir_y_neg;
        err_t   error_term;
        logic   finished;
    } bls_state_t;

    typedef struct packed {
        coord_t              pixel_x;
        coord_t              pixel_y;
        logic [ADDR_W-1:0]   pixel_address;
        logic [COLOR_W-1:0]  pixel_color;
        logic                write_enable;
        logic                done_res;
    } bls_result_t;

    localparam bls_state_t STATE_RST = '{finished: 1'b1, default: '0};

endpackage

// ===== sv/bls_item_if.sv =====
// Input channel: load and step words.
`timescale 1ns / 1ps

interface bls_item_if;
    import bls_pkg::*;

    logic   valid;
    logic   ready;
    logic   op;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;

    modport source (output valid, op, x_start, y_start, x_end, y_end, input ready);
    modport sink   (input valid, op, x_start, y_start, x_end, y_end, output ready);
endinterface

// ===== sv/bls_pixel_if.sv =====
// Output channel: pixel write words.
`timescale 1ns / 1ps

interface bls_pixel_if;
    import bls_pkg::*;

    logic                valid;
    logic                ready;
    coord_t              pixel_x;
    coord_t              pixel_y;
    logic [ADDR_W-1:0]   pixel_address;
    logic [COLOR_W-1:0]  pixel_color;
    logic                write_enable;
    logic                done_res;

    modport source (output valid, pixel_x, pixel_y, pixel_address, pixel_color,
                    write_enable, done_res, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_address, pixel_color,
                    write_enable, done_res, output ready);
endinterface

// ===== sv/bls_cfg_if.sv =====
// Configuration write channel.
`timescale 1ns / 1ps

interface bls_cfg_if;
    import bls_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [COLOR_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/bls_step_unit.sv =====
// Next line state for a load or a step word.
`timescale 1ns / 1ps

module bls_step_unit (
    input  logic                op,
    input  bls_pkg::coord_t     x_start,
    input  bls_pkg::coord_t     y_start,
    input  bls_pkg::coord_t     x_end,
    input  bls_pkg::coord_t     y_end,
    input  bls_pkg::bls_state_t state,
    output bls_pkg::bls_state_t state_next
);
    import bls_pkg::*;

    logic signed [COORD_W:0]   diff_x;
    logic signed [COORD_W:0]   diff_y;
    logic signed [COORD_W:0]   mag_x;
    logic signed [COORD_W:0]   mag_y;
    bls_state_t                load_state;
    bls_state_t                step_state;
    logic                      at_end;
    logic signed [ERR_W:0]     e2;
    logic signed [ERR_W:0]     dx_w;
    logic signed [ERR_W:0]     dy_w;
    logic                      move_x;
    logic                      move_y;
    logic signed [ERR_W:0]     err_sum;
    coord_t                    inc_x;
    coord_t                    inc_y;

    always_comb
    begin
        diff_x = {x_start[COORD_W-1], x_start} - {x_end[COORD_W-1], x_end};
        diff_y = {y_start[COORD_W-1], y_start} - {y_end[COORD_W-1], y_end};
        mag_x  = diff_x[COORD_W] ? -diff_x : diff_x;
        mag_y  = diff_y[COORD_W] ? -diff_y : diff_y;

        load_state            = state;
        load_state.cur_x      = x_start;
        load_state.cur_y      = y_start;
        load_state.target_x   = x_end;
        load_state.target_y   = y_end;
        load_state.abs_dx     = mag_x[DELTA_W-1:0];
        load_state.abs_dy     = mag_y[DELTA_W-1:0];
        load_state.dir_x_neg  = !(x_start < x_end);
        load_state.dir_y_neg  = !(y_start < y_end);
        load_state.error_term = $signed({{(ERR_W-DELTA_W){1'b0}}, mag_x[DELTA_W-1:0]})
                              - $signed({{(ERR_W-DELTA_W){1'b0}}, mag_y[DELTA_W-1:0]});
        load_state.finished   = 1'b0;

        // One Bresenham step; mark the line finished at the endpoint, then hold everything
        at_end  = (state.cur_x == state.target_x) && (state.cur_y == state.target_y);
        e2      = {state.error_term, 1'b0};
        dx_w    = $signed({{(ERR_W+1-DELTA_W){1'b0}}, state.abs_dx});
        dy_w    = $signed({{(ERR_W+1-DELTA_W){1'b0}}, state.abs_dy});
        move_x  = e2 > -dy_w;
        move_y  = e2 < dx_w;
        err_sum = {state.error_term[ERR_W-1], state.error_term}
                - (move_x ? dy_w : '0) + (move_y ? dx_w : '0);
        inc_x   = state.dir_x_neg ? -12'sd1 : 12'sd1;
        inc_y   = state.dir_y_neg ? -12'sd1 : 12'sd1;

        step_state = state;
        if (!state.finished)
        begin
            if (at_end)
            begin
                step_state.finished = 1'b1;
            end
            else
            begin
                step_state.error_term = err_sum[ERR_W-1:0];
                if (move_x)
                begin
                    step_state.cur_x = state.cur_x + inc_x;
                end
                if (move_y)
                begin
                    step_state.cur_y = state.cur_y + inc_y;
                end
            end
        end

        state_next = (op == OP_LOAD) ? load_state : step_state;
    end
endmodule

// ===== sv/bls_pixel_unit.sv =====
// Clip test, framebuffer address and result word for the current point.
`timescale 1ns / 1ps

module bls_pixel_unit #(
    parameter int FB_WIDTH  = 320,
    parameter int FB_HEIGHT = 240
) (
    input  bls_pkg::bls_state_t             state,
    input  logic [bls_pkg::COLOR_W-1:0]     draw_color,
    input  logic [bls_pkg::LEFT_W-1:0]      canvas_left,
    output bls_pkg::bls_result_t            result
);
    import bls_pkg::*;

    localparam int PROD_W = 2 * COORD_W;
    localparam logic [COORD_W:0] FB_W_C = (COORD_W+1)'(FB_WIDTH);
    localparam logic [COORD_W:0] FB_H_C = (COORD_W+1)'(FB_HEIGHT);

    logic              on_canvas;
    logic              in_fb;
    logic              we;
    logic              at_end;
    logic [PROD_W-1:0] addr_full;

    always_comb
    begin
        on_canvas = state.cur_x > $signed({{(COORD_W-LEFT_W){1'b0}}, canvas_left});
        in_fb     = !state.cur_x[COORD_W-1] && !state.cur_y[COORD_W-1]
                 && ({1'b0, state.cur_x} < FB_W_C) && ({1'b0, state.cur_y} < FB_H_C);
        we        = on_canvas && in_fb && !state.finished;
        at_end    = (state.cur_x == state.target_x) && (state.cur_y == state.target_y);
        addr_full = PROD_W'(unsigned'(state.cur_y)) * PROD_W'(FB_WIDTH)
                  + PROD_W'(unsigned'(state.cur_x));

        result.pixel_x       = state.cur_x;
        result.pixel_y       = state.cur_y;
        result.pixel_color   = draw_color;
        result.write_enable  = we;
        result.pixel_address = we ? addr_full[ADDR_W-1:0] : '0;
        result.done_res      = state.finished || at_end;
    end
endmodule

// ===== sv/bresenham_line_stepper_core.sv =====
// Top level of the Bresenham line stepper with clipping.
`timescale 1ns / 1ps

// Bresenham line stepper. A load word (op = 0) latches two signed 12-bit
// endpoints and sets up the deltas, step directions and error term; it
// yields no output word. Each step word (op = 1) yields one pixel word for
// the current point, then advances the point by one Bresenham step.
// write_enable is set only when x > canvas_left and the point lies inside
// the FB_WIDTH x FB_HEIGHT framebuffer; pixel_address is y*FB_WIDTH+x
// (17 bits) when written and zero otherwise. done_res flags the endpoint;
// steps after it repeat the last point with write_enable low and done_res
// high. Rate: one word per clock unless the output stalls; pixel words
// are registered. The line state register is updated in the accepting
// cycle, and the clip test and the constant multiply for the address
// feed the output register directly. The input side stalls only while
// the output register is full and not being taken. Configuration writes
// are always accepted and take effect on the next word.

module bresenham_line_stepper_core #(
    parameter int FB_WIDTH  = 320,
    parameter int FB_HEIGHT = 240
) (
    input  logic            clk,
    input  logic            rst_n,
    bls_item_if.sink        item,
    bls_pixel_if.source     pixel,
    bls_cfg_if.sink         cfg
);
    import bls_pkg::*;

    logic [COLOR_W-1:0] draw_color_reg;
    logic [LEFT_W-1:0]  canvas_left_reg;
    bls_state_t         state_reg;
    bls_state_t         state_next;
    bls_result_t        result_next;
    bls_result_t        result_reg;
    logic               out_valid_reg;
    logic               item_accept;
    logic               step_accept;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draw_color_reg  <= DRAW_COLOR_RST;
            canvas_left_reg <= CANVAS_LEFT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_DRAW_COLOR:  draw_color_reg  <= cfg.data;
                REG_CANVAS_LEFT: canvas_left_reg <= cfg.data[LEFT_W-1:0];
                default:         ;  // drop writes to unknown indexes
            endcase
        end
    end

    // Accept a word whenever the output register is free or being drained
    assign item.ready  = !out_valid_reg || pixel.ready;
    assign item_accept = item.valid && item.ready;
    assign step_accept = item_accept && (item.op == OP_STEP);

    bls_step_unit u_step (
        .op         (item.op),
        .x_start    (item.x_start),
        .y_start    (item.y_start),
        .x_end      (item.x_end),
        .y_end      (item.y_end),
        .state      (state_reg),
        .state_next (state_next)
    );

    bls_pixel_unit #(
        .FB_WIDTH  (FB_WIDTH),
        .FB_HEIGHT (FB_HEIGHT)
    ) u_pixel (
        .state       (state_reg),
        .draw_color  (draw_color_reg),
        .canvas_left (canvas_left_reg),
        .result      (result_next)
    );

    // Line state: advance on every accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RST;
        end
        else if (item_accept)
        begin
            state_reg <= state_next;
        end
    end

    // Output register: load on a step word, clear valid once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pixel.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_accept)
        begin
            result_reg <= result_next;
        end
    end

    assign pixel.valid         = out_valid_reg;
    assign pixel.pixel_x       = result_reg.pixel_x;
    assign pixel.pixel_y       = result_reg.pixel_y;
    assign pixel.pixel_address = result_reg.pixel_address;
    assign pixel.pixel_color   = result_reg.pixel_color;
    assign pixel.write_enable  = result_reg.write_enable;
    assign pixel.done_res      = result_reg.done_res;

    // A load always starts an unfinished line
    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && item.op == OP_LOAD) |=> !state_reg.finished)
        else $error("line not active after load");

    // Steps on a finished line leave the line state untouched
    a_finished_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (step_accept && state_reg.finished) |=> $stable(state_reg))
        else $error("finished line state changed");

    // Never overwrite a pending output word
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pixel.ready) |-> !step_accept)
        else $error("step accepted while output stalled");

    // A suppressed write carries a zero address
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_reg.write_enable) |-> (result_reg.pixel_address == '0))
        else $error("address set on suppressed write");

endmodule
